### hw/rtl/tlm_pkg.sv
// Shared constants, register codes, status codes and types of the thermistor and light monitor.
// Depends on nothing; every other file of the block uses it.
package tlm_pkg;

	localparam int ADC_BITS_DEF  = 12;
	localparam int TEMP_FRAC_DEF = 8;

	// Field and register widths.
	localparam int BETA_W     = 14;
	localparam int LIMIT_W    = 12;
	localparam int TEMP_W     = 13;
	localparam int PCT_W      = 7;
	localparam int STAT_W     = 2;
	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 3;

	// Logarithm: Q30 mantissa in [1,2) and 16 fraction bits of result.
	localparam int MANT_W     = 31;
	localparam int LOG_FRAC_W = 16;

	// ln(2) in Q30 and T0 = 298.15 K in Q16.
	localparam int              LN2_FRAC = 30;
	localparam logic [29:0]     LN2_Q30  = 30'd744261118;
	localparam int              T0_W     = 25;
	localparam logic [T0_W-1:0] T0_Q16   = 25'd19539558;

	localparam int CLAMP_MARGIN = 10;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -13'sd1000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sd3000;
	localparam logic [PCT_W-1:0]         PCT_FULL = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BETA,
		REG_DARK,
		REG_BRIGHT,
		REG_ALARM,
		REG_WARN,
		REG_LIGHT_HIGH,
		REG_LIGHT_MID
	} cfg_reg_t;

	localparam logic [STAT_W-1:0] TSTAT_NORMAL   = 2'd0;
	localparam logic [STAT_W-1:0] TSTAT_MEDIUM   = 2'd1;
	localparam logic [STAT_W-1:0] TSTAT_CRITICAL = 2'd2;

	localparam logic [STAT_W-1:0] LSTAT_LOW    = 2'd0;
	localparam logic [STAT_W-1:0] LSTAT_NORMAL = 2'd1;
	localparam logic [STAT_W-1:0] LSTAT_HIGH   = 2'd2;

	localparam logic [STAT_W-1:0] BAND_DARK   = 2'd0;
	localparam logic [STAT_W-1:0] BAND_MID    = 2'd1;
	localparam logic [STAT_W-1:0] BAND_BRIGHT = 2'd2;

	// Light thresholds handed to the light path.
	typedef struct packed {
		logic [LIMIT_W-1:0] dark_limit;
		logic [LIMIT_W-1:0] bright_limit;
		logic [PCT_W-1:0]   high_pct;
		logic [PCT_W-1:0]   mid_pct;
	} light_cfg_t;

endpackage

### hw/rtl/tlm_in_if.sv
// Request channel carrying one thermistor and light sample pair.
// Depends on tlm_pkg.
interface tlm_in_if #(
	parameter int ADC_BITS = tlm_pkg::ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] thermistor_code;
	logic [ADC_BITS-1:0] light_code_raw;

	modport source (output valid, thermistor_code, light_code_raw, input ready);
	modport sink   (input valid, thermistor_code, light_code_raw, output ready);
endinterface

### hw/rtl/tlm_out_if.sv
// Result channel carrying temperature and light readings with their status codes.
// Depends on tlm_pkg.
interface tlm_out_if;
	import tlm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_tenths;
	logic                     over_temp;
	logic [STAT_W-1:0]        temp_status;
	logic [STAT_W-1:0]        light_band;
	logic [PCT_W-1:0]         light_percent;
	logic [STAT_W-1:0]        light_status;

	modport source (output valid, temp_tenths, over_temp, temp_status, light_band,
		light_percent, light_status, input ready);
	modport sink   (input valid, temp_tenths, over_temp, temp_status, light_band,
		light_percent, light_status, output ready);
endinterface

### hw/rtl/tlm_log2_pipe.sv
// Two-lane fractional log2 pipeline: one squaring of each Q30 mantissa per stage.
// Depends on tlm_pkg.
module tlm_log2_pipe #(
	parameter int SB_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [tlm_pkg::MANT_W-1:0]     in_ma,
	input  logic [tlm_pkg::MANT_W-1:0]     in_mb,
	input  logic [SB_W-1:0]               in_sb,
	output logic                          out_valid,
	output logic [tlm_pkg::LOG_FRAC_W-1:0] out_fa,
	output logic [tlm_pkg::LOG_FRAC_W-1:0] out_fb,
	output logic [SB_W-1:0]               out_sb
);
	import tlm_pkg::*;

	localparam int STAGES = LOG_FRAC_W;

	logic [STAGES-1:0]     valid_s;
	logic [MANT_W-1:0]     ma_s [STAGES];
	logic [MANT_W-1:0]     mb_s [STAGES];
	logic [LOG_FRAC_W-1:0] fa_s [STAGES];
	logic [LOG_FRAC_W-1:0] fb_s [STAGES];
	logic [SB_W-1:0]       sb_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic                  v_in;
		logic [MANT_W-1:0]     ma_in, mb_in;
		logic [LOG_FRAC_W-1:0] fa_in, fb_in, fa_nx, fb_nx;
		logic [SB_W-1:0]       sb_in;
		logic [2*MANT_W-1:0]   pa, pb;
		logic [MANT_W:0]       sqa, sqb;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign ma_in = in_ma;
			assign mb_in = in_mb;
			assign fa_in = '0;
			assign fb_in = '0;
			assign sb_in = in_sb;
		end else begin : g_next
			assign v_in  = valid_s[k-1];
			assign ma_in = ma_s[k-1];
			assign mb_in = mb_s[k-1];
			assign fa_in = fa_s[k-1];
			assign fb_in = fb_s[k-1];
			assign sb_in = sb_s[k-1];
		end

		assign pa  = ma_in * ma_in;
		assign pb  = mb_in * mb_in;
		assign sqa = pa[2*MANT_W-1:MANT_W-1];
		assign sqb = pb[2*MANT_W-1:MANT_W-1];

		// A square at or above two yields the next result bit and is halved.
		always_comb begin
			fa_nx = fa_in;
			fb_nx = fb_in;
			fa_nx[STAGES-1-k] = sqa[MANT_W];
			fb_nx[STAGES-1-k] = sqb[MANT_W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ma_s[k] <= sqa[MANT_W] ? sqa[MANT_W:1] : sqa[MANT_W-1:0];
				mb_s[k] <= sqb[MANT_W] ? sqb[MANT_W:1] : sqb[MANT_W-1:0];
				fa_s[k] <= fa_nx;
				fb_s[k] <= fb_nx;
				sb_s[k] <= sb_in;
			end
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign out_fa    = fa_s[STAGES-1];
	assign out_fb    = fb_s[STAGES-1];
	assign out_sb    = sb_s[STAGES-1];

endmodule

### hw/rtl/tlm_div_pipe.sv
// Restoring divider pipeline: one quotient bit per stage, numerator bits taken msb first.
// Depends on tlm_pkg.
module tlm_div_pipe #(
	parameter int NUM_W = 47,
	parameter int DIV_W = 31,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DIV_W-1:0] in_den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_quo,
	output logic [SB_W-1:0]  out_sb
);
	import tlm_pkg::*;

	logic [NUM_W-1:0] valid_s;
	logic [DIV_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [DIV_W-1:0] den_s [NUM_W];
	logic [SB_W-1:0]  sb_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic             v_in;
		logic [DIV_W-1:0] rem_in, den_in;
		logic [NUM_W-1:0] num_in, quo_in;
		logic [SB_W-1:0]  sb_in;
		logic [DIV_W:0]   trial, diff;
		logic             fits;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign num_in = in_num;
			assign quo_in = '0;
			assign den_in = in_den;
			assign sb_in  = in_sb;
		end else begin : g_next
			assign v_in   = valid_s[k-1];
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign sb_in  = sb_s[k-1];
		end

		assign trial = {rem_in, num_in[NUM_W-1]};
		assign diff  = trial - {1'b0, den_in};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				num_s[k] <= num_in << 1;
				quo_s[k] <= {quo_in[NUM_W-2:0], fits};
				den_s[k] <= den_in;
				sb_s[k]  <= sb_in;
			end
		end
	end

	assign out_valid = valid_s[NUM_W-1];
	assign out_quo   = quo_s[NUM_W-1];
	assign out_sb    = sb_s[NUM_W-1];

endmodule

### hw/rtl/tlm_light.sv
// Two-stage light path: inversion, band, percentage by reciprocal multiply, light status.
// Depends on tlm_pkg.
module tlm_light #(
	parameter int ADC_BITS = tlm_pkg::ADC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ADC_BITS-1:0]        raw,
	input  tlm_pkg::light_cfg_t        cfg,
	output logic [tlm_pkg::STAT_W-1:0] band,
	output logic [tlm_pkg::PCT_W-1:0]  pct,
	output logic [tlm_pkg::STAT_W-1:0] lstat
);
	import tlm_pkg::*;

	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	localparam int X_W     = ADC_BITS + 7;
	localparam int SHIFT   = X_W;
	localparam int RECIP   = (1 << SHIFT) / ADC_MAX;
	localparam int K       = 100 * RECIP;
	localparam int K_W     = $clog2(K + 1);
	localparam int P_W     = ADC_BITS + K_W;
	localparam int CMP_W   = (ADC_BITS > LIMIT_W) ? ADC_BITS : LIMIT_W;

	logic [ADC_BITS-1:0] inv;
	logic [P_W-1:0]      est;
	logic [STAT_W-1:0]   band_nx;
	logic [X_W-1:0]      x_s1;
	logic [PCT_W-1:0]    q0_s1;
	logic [STAT_W-1:0]   band_s1;
	logic [X_W:0]        rem;
	logic [PCT_W-1:0]    pct_nx;
	logic [STAT_W-1:0]   lstat_nx;

	assign inv = ADC_BITS'(ADC_MAX) - raw;
	assign est = P_W'(inv) * P_W'(K);

	// The dark test goes first, so it wins over mid where the limits cross.
	always_comb begin
		priority if (CMP_W'(inv) < CMP_W'(cfg.dark_limit)) begin
			band_nx = BAND_DARK;
		end else if (CMP_W'(inv) <= CMP_W'(cfg.bright_limit)) begin
			band_nx = BAND_MID;
		end else begin
			band_nx = BAND_BRIGHT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= X_W'(inv) * X_W'(100);
			q0_s1   <= PCT_W'(est >> SHIFT);
			band_s1 <= band_nx;
		end
	end

	// The estimate is low by at most one; the remainder decides the correction.
	assign rem    = (X_W+1)'(x_s1) + (X_W+1)'(q0_s1) - ((X_W+1)'(q0_s1) << ADC_BITS);
	assign pct_nx = q0_s1 + PCT_W'(rem >= (X_W+1)'(ADC_MAX));

	always_comb begin
		priority if (pct_nx > cfg.high_pct) begin
			lstat_nx = LSTAT_HIGH;
		end else if (pct_nx > cfg.mid_pct) begin
			lstat_nx = LSTAT_NORMAL;
		end else begin
			lstat_nx = LSTAT_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			band  <= band_s1;
			pct   <= pct_nx;
			lstat <= lstat_nx;
		end
	end

endmodule

### hw/rtl/thermistor_light_monitor_core.sv
// Top level of the thermistor and light monitor: configuration registers and the pipeline.
// Depends on tlm_pkg, tlm_in_if, tlm_out_if, tlm_log2_pipe, tlm_div_pipe and tlm_light.
//
//   Port      Kind          Direction  Carries
//   samples   valid/ready   in         thermistor_code, light_code_raw
//   results   valid/ready   out        temp_tenths, over_temp, temp_status,
//                                      light_band, light_percent, light_status
//   wr_*      write only    in         register index and data, no handshake
//
// One request enters per cycle while the output is not held, and its result leaves after
// one front stage,
// sixteen squaring stages of the logarithm, four stages for ln r and the denominator,
// one stage per quotient bit of the divider, and two closing stages.
// The whole pipeline advances on one enable, which is low only while the output
// register holds a result that is not taken; nothing is dropped or repeated.
// Reset clears all valid bits and returns the registers to their documented defaults.
module thermistor_light_monitor_core #(
	parameter int ADC_BITS       = tlm_pkg::ADC_BITS_DEF,
	parameter int TEMP_FRAC_BITS = tlm_pkg::TEMP_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tlm_in_if.sink                         samples,
	tlm_out_if.source                      results,
	input  logic                           wr_en,
	input  logic [tlm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tlm_pkg::CFG_DATA_W-1:0] wr_data
);
	import tlm_pkg::*;

	// Widths of the temperature path. L values are e.Q16 log2 numbers.
	localparam int EW        = $clog2(ADC_BITS);
	localparam int L_W       = EW + LOG_FRAC_W;
	localparam int LN_PROD_W = L_W + LN2_FRAC;
	localparam int PROD_W    = L_W + T0_W - 16;
	localparam int BASE_W    = BETA_W + 16;
	localparam int DEN_W     = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 2;
	localparam int DIV_W     = DEN_W - 1;
	localparam int BT_W      = BETA_W + T0_W;
	localparam int NUM_W     = BT_W + TEMP_FRAC_BITS;
	localparam int SC_W      = NUM_W + 5;
	localparam int TQ_W      = SC_W - TEMP_FRAC_BITS;
	localparam int LOG_SB_W  = 2 * EW + ADC_BITS;
	localparam int DIV_SB_W  = 1 + ADC_BITS;

	localparam longint ZERO_C    = ((longint'(27315) << TEMP_FRAC_BITS) + 50) / 100;
	localparam longint ROUND_ADD = (longint'(1) << TEMP_FRAC_BITS) - 1;

	localparam logic [ADC_BITS-1:0] ADC_MAX  = ADC_BITS'((1 << ADC_BITS) - 1);
	localparam logic [ADC_BITS-1:0] CLAMP_LO = ADC_BITS'(CLAMP_MARGIN);
	localparam logic [ADC_BITS-1:0] CLAMP_HI = ADC_MAX - CLAMP_LO;

	// Configuration registers.
	logic [BETA_W-1:0]        beta_q;
	logic [LIMIT_W-1:0]       dark_q, bright_q;
	logic signed [TEMP_W-1:0] alarm_q, warn_q;
	logic [PCT_W-1:0]         light_high_q, light_mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q       <= BETA_W'(3950);
			dark_q       <= LIMIT_W'(500);
			bright_q     <= LIMIT_W'(1000);
			alarm_q      <= TEMP_W'(400);
			warn_q       <= TEMP_W'(300);
			light_high_q <= PCT_W'(80);
			light_mid_q  <= PCT_W'(40);
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_BETA:       beta_q       <= wr_data;
				REG_DARK:       dark_q       <= wr_data[LIMIT_W-1:0];
				REG_BRIGHT:     bright_q     <= wr_data[LIMIT_W-1:0];
				REG_ALARM:      alarm_q      <= wr_data[TEMP_W-1:0];
				REG_WARN:       warn_q       <= wr_data[TEMP_W-1:0];
				REG_LIGHT_HIGH: light_high_q <= wr_data[PCT_W-1:0];
				REG_LIGHT_MID:  light_mid_q  <= wr_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it stops only when the output is held.
	logic en;
	logic valid_s7;

	assign en            = !valid_s7 || results.ready;
	assign samples.ready = en;

	// Stage 1: clamp the thermistor code and normalize both divider arms.
	function automatic logic [EW-1:0] msb_pos(input logic [ADC_BITS-1:0] x);
		logic [EW-1:0] p;
		p = '0;
		for (int i = 0; i < ADC_BITS; i++) begin
			if (x[i]) begin
				p = EW'(i);
			end
		end
		return p;
	endfunction

	logic [ADC_BITS-1:0] code_c, arm_a, arm_b;
	logic [EW-1:0]       ea, eb;
	logic                valid_s1;
	logic [MANT_W-1:0]   ma_s1, mb_s1;
	logic [EW-1:0]       ea_s1, eb_s1;
	logic [ADC_BITS-1:0] light_s1;

	always_comb begin
		priority if (samples.thermistor_code < CLAMP_LO) begin
			code_c = CLAMP_LO;
		end else if (samples.thermistor_code > CLAMP_HI) begin
			code_c = CLAMP_HI;
		end else begin
			code_c = samples.thermistor_code;
		end
	end

	// Arm a is the series resistor side, arm b the thermistor side.
	assign arm_a = ADC_MAX - code_c;
	assign arm_b = code_c;
	assign ea    = msb_pos(arm_a);
	assign eb    = msb_pos(arm_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1    <= (MANT_W'(arm_a) << (MANT_W - ADC_BITS)) << (EW'(ADC_BITS - 1) - ea);
			mb_s1    <= (MANT_W'(arm_b) << (MANT_W - ADC_BITS)) << (EW'(ADC_BITS - 1) - eb);
			ea_s1    <= ea;
			eb_s1    <= eb;
			light_s1 <= samples.light_code_raw;
		end
	end

	// Fraction bits of both logarithms.
	logic                  lg_valid;
	logic [LOG_FRAC_W-1:0] lg_fa, lg_fb;
	logic [LOG_SB_W-1:0]   lg_sb;

	tlm_log2_pipe #(
		.SB_W(LOG_SB_W)
	) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.in_ma    (ma_s1),
		.in_mb    (mb_s1),
		.in_sb    ({ea_s1, eb_s1, light_s1}),
		.out_valid(lg_valid),
		.out_fa   (lg_fa),
		.out_fb   (lg_fb),
		.out_sb   (lg_sb)
	);

	// Stage 2: log2 r as a magnitude and a sign.
	logic [L_W-1:0]      la, lb;
	logic                valid_s2, neg_s2;
	logic [L_W-1:0]      mag_s2;
	logic [ADC_BITS-1:0] light_s2;

	assign la = {lg_sb[LOG_SB_W-1 -: EW], lg_fa};
	assign lb = {lg_sb[ADC_BITS +: EW], lg_fb};

	// Stage 3: ln r, and the numerator beta * T0 in parallel.
	logic                valid_s3, neg_s3;
	logic [L_W-1:0]      lnmag_s3;
	logic [BT_W-1:0]     num_s3;
	logic [ADC_BITS-1:0] light_s3;
	logic [LN_PROD_W-1:0] ln_prod;

	assign ln_prod = LN_PROD_W'(mag_s2) * LN_PROD_W'(LN2_Q30);

	// Stage 4: T0 * ln r in Q16.
	logic                 valid_s4, neg_s4;
	logic [PROD_W-1:0]    prod_s4;
	logic [BT_W-1:0]      num_s4;
	logic [ADC_BITS-1:0]  light_s4;
	logic [L_W+T0_W-1:0]  t0_prod;

	assign t0_prod = (L_W + T0_W)'(lnmag_s3) * (L_W + T0_W)'(T0_Q16);

	// Stage 5: denominator beta + T0 ln r; a non-positive one means unbounded hot.
	logic signed [DEN_W-1:0] den_base, den_term, den;
	logic                    valid_s5, hot_s5;
	logic [DIV_W-1:0]        den_s5;
	logic [NUM_W-1:0]        num_s5;
	logic [ADC_BITS-1:0]     light_s5;

	assign den_base = DEN_W'({beta_q, 16'b0});
	assign den_term = DEN_W'(prod_s4);
	assign den      = neg_s4 ? (den_base - den_term) : (den_base + den_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s2 <= lg_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2   <= la < lb;
			mag_s2   <= (la < lb) ? (lb - la) : (la - lb);
			light_s2 <= lg_sb[ADC_BITS-1:0];

			neg_s3   <= neg_s2;
			lnmag_s3 <= ln_prod[LN_PROD_W-1:LN2_FRAC];
			num_s3   <= BT_W'(beta_q) * BT_W'(T0_Q16);
			light_s3 <= light_s2;

			neg_s4   <= neg_s3;
			prod_s4  <= t0_prod[L_W+T0_W-1:16];
			num_s4   <= num_s3;
			light_s4 <= light_s3;

			hot_s5   <= den <= DEN_W'(0);
			den_s5   <= den[DIV_W-1:0];
			num_s5   <= NUM_W'(num_s4) << TEMP_FRAC_BITS;
			light_s5 <= light_s4;
		end
	end

	// Kelvin temperature in 1/2^TEMP_FRAC_BITS degree.
	logic                dv_valid;
	logic [NUM_W-1:0]    dv_quo;
	logic [DIV_SB_W-1:0] dv_sb;

	tlm_div_pipe #(
		.NUM_W(NUM_W),
		.DIV_W(DIV_W),
		.SB_W (DIV_SB_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_sb    ({hot_s5, light_s5}),
		.out_valid(dv_valid),
		.out_quo  (dv_quo),
		.out_sb   (dv_sb)
	);

	// Stage 6: Celsius and times ten, at full precision for the threshold tests.
	logic signed [NUM_W:0]  t_c;
	logic signed [SC_W-1:0] t_x;
	logic                   valid_s6, hot_s6;
	logic signed [SC_W-1:0] scaled_s6;

	assign t_c = $signed({1'b0, dv_quo}) - (NUM_W + 1)'(ZERO_C);
	assign t_x = SC_W'(t_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hot_s6    <= dv_sb[DIV_SB_W-1];
			scaled_s6 <= (t_x <<< 3) + (t_x <<< 1);
		end
	end

	// The light path runs alongside the last two stages.
	light_cfg_t light_cfg;

	assign light_cfg = '{dark_limit: dark_q, bright_limit: bright_q,
		high_pct: light_high_q, mid_pct: light_mid_q};

	tlm_light #(
		.ADC_BITS(ADC_BITS)
	) u_light (
		.clk  (clk),
		.en   (en),
		.raw  (dv_sb[ADC_BITS-1:0]),
		.cfg  (light_cfg),
		.band (results.light_band),
		.pct  (results.light_percent),
		.lstat(results.light_status)
	);

	// Stage 7: truncate toward zero to tenths, saturate, and test the thresholds.
	logic signed [SC_W-1:0]   rounded, alarm_x, warn_x;
	logic signed [TQ_W-1:0]   tq;
	logic signed [TEMP_W-1:0] tenths_nx;
	logic                     over_nx;
	logic [STAT_W-1:0]        tstat_nx;
	logic signed [TEMP_W-1:0] tenths_s7;
	logic                     over_s7;
	logic [STAT_W-1:0]        tstat_s7;

	assign rounded = (scaled_s6 < 0) ? (scaled_s6 + SC_W'(ROUND_ADD)) : scaled_s6;
	assign tq      = TQ_W'(rounded >>> TEMP_FRAC_BITS);
	assign alarm_x = SC_W'(alarm_q) <<< TEMP_FRAC_BITS;
	assign warn_x  = SC_W'(warn_q) <<< TEMP_FRAC_BITS;

	always_comb begin
		priority if (hot_s6) begin
			tenths_nx = TEMP_MAX;
		end else if (tq < TQ_W'(TEMP_MIN)) begin
			tenths_nx = TEMP_MIN;
		end else if (tq > TQ_W'(TEMP_MAX)) begin
			tenths_nx = TEMP_MAX;
		end else begin
			tenths_nx = TEMP_W'(tq);
		end
	end

	assign over_nx = hot_s6 || (scaled_s6 > alarm_x);

	always_comb begin
		priority if (over_nx) begin
			tstat_nx = TSTAT_CRITICAL;
		end else if (scaled_s6 > warn_x) begin
			tstat_nx = TSTAT_MEDIUM;
		end else begin
			tstat_nx = TSTAT_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tenths_s7 <= tenths_nx;
			over_s7   <= over_nx;
			tstat_s7  <= tstat_nx;
		end
	end

	assign results.valid       = valid_s7;
	assign results.temp_tenths = tenths_s7;
	assign results.over_temp   = over_s7;
	assign results.temp_status = tstat_s7;

`ifndef NO_ASSERTIONS
	a_alarm_status: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.over_temp == (results.temp_status == TSTAT_CRITICAL)))
		else $error("alarm and critical status disagree");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.temp_tenths >= TEMP_MIN && results.temp_tenths <= TEMP_MAX))
		else $error("temperature outside the saturation range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.light_percent <= PCT_FULL))
		else $error("light percentage above full scale");

	a_hot_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s6 && hot_s6) |=>
			(results.temp_tenths == TEMP_MAX && results.over_temp))
		else $error("non-positive denominator did not give the hot result");
`endif

endmodule

### verif/thermistor_light_monitor_core_test.sv
// Testbench of the thermistor and light monitor core: directed and random sample pairs,
// several register settings, a bit-true temperature and light predictor and an ordered checker.
// Depends on tlm_pkg, tlm_in_if, tlm_out_if and thermistor_light_monitor_core.
module thermistor_light_monitor_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tlm_pkg::*;

	localparam int ADC_MAX = 4095;
	localparam int LATENCY = 70;
	localparam longint ZERO_C_Q = ((64'd27315 << 8) + 64'd50) / 64'd100;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [11:0] therm;
		logic [11:0] light;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_tenths;
		logic                     over_temp;
		logic [STAT_W-1:0]        temp_status;
		logic [STAT_W-1:0]        light_band;
		logic [PCT_W-1:0]         light_percent;
		logic [STAT_W-1:0]        light_status;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	tlm_in_if samples ();
	tlm_out_if results ();

	thermistor_light_monitor_core DUT (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// Shadow copy of the configuration registers, kept in step with every write.
	logic [13:0] beta_k;
	logic [11:0] dark_lim, bright_lim;
	logic signed [12:0] alarm_t, warn_t;
	logic [6:0] high_pct, mid_pct;

	// Directed codes: clamp edges, mid scale, band and percent edges, small beta sweep.
	logic [11:0] dir_therm [12] = '{12'd0, 12'd9, 12'd10, 12'd11, 12'd1000, 12'd2047,
		12'd2048, 12'd3000, 12'd4084, 12'd4085, 12'd4086, 12'd4095};
	logic [11:0] dir_light [12] = '{12'd4095, 12'd0, 12'd3596, 12'd3595, 12'd3095,
		12'd3094, 12'd2457, 12'd819, 12'd1, 12'd2730, 12'd4094, 12'hAAA};
	logic [11:0] sweep_therm [8] = '{12'd0, 12'd10, 12'd100, 12'd500, 12'd2048,
		12'd3500, 12'd4085, 12'd4095};

	sample_t  pending_samples[$];
	reading_t expected_readings[$];
	int  mismatch_count = 0;
	longint cycle_count = 0;
	int  send_gap = 0;
	int  take_gap = 0;
	bit  hold_sender = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL thermistor_light_monitor_core");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one, and runs with none at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// log2 in Q16: msb position as integer part, then sixteen truncated squarings.
	function automatic logic [31:0] log2_q16(input logic [31:0] x);
		logic [31:0] e;
		logic [63:0] m;
		logic [31:0] r;
		e = 0;
		while (e < 16 && (x >> (e + 1)) != 0) e++;
		m = 64'(x) << (30 - e);
		r = e << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic reading_t predict_reading(input sample_t s);
		reading_t o;
		logic [31:0] a, la, lb, mag, lnmag, inv, pct;
		bit neg;
		longint den, tk, t, scaled, tenths, prod;
		logic [63:0] num;
		a = s.therm;
		if (a < 10) a = 10;
		if (a > ADC_MAX - 10) a = ADC_MAX - 10;
		la = log2_q16(ADC_MAX - a);
		lb = log2_q16(a);
		neg = la < lb;
		mag = neg ? lb - la : la - lb;
		lnmag = 32'((64'(mag) * 64'd744261118) >> 30);
		prod = longint'((64'(lnmag) * 64'd19539558) >> 16);
		den = (longint'(beta_k) << 16) + (neg ? -prod : prod);
		// A zero or negative denominator stands for an unbounded hot reading.
		if (den <= 0) tk = 64'sd1 <<< 56;
		else begin
			num = (64'(beta_k) * 64'd19539558) << 8;
			tk = longint'(num / 64'(den));
		end
		t = tk - ZERO_C_Q;
		scaled = t * 10;
		tenths = scaled / 256;
		if (tenths < -1000) tenths = -1000;
		if (tenths > 3000) tenths = 3000;
		o.temp_tenths = 13'(tenths);
		o.over_temp = scaled > longint'(alarm_t) * 256;
		if (o.over_temp) o.temp_status = TSTAT_CRITICAL;
		else if (scaled > longint'(warn_t) * 256) o.temp_status = TSTAT_MEDIUM;
		else o.temp_status = TSTAT_NORMAL;
		inv = ADC_MAX - s.light;
		// The dark test comes first, so it wins when the limits cross.
		if (inv < dark_lim) o.light_band = BAND_DARK;
		else if (inv <= bright_lim) o.light_band = BAND_MID;
		else o.light_band = BAND_BRIGHT;
		pct = (inv * 100) / ADC_MAX;
		o.light_percent = 7'(pct);
		if (pct > high_pct) o.light_status = LSTAT_HIGH;
		else if (pct > mid_pct) o.light_status = LSTAT_NORMAL;
		else o.light_status = LSTAT_LOW;
		return o;
	endfunction

	// Driver: presents queued requests, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples.valid <= 1'b0;
			samples.thermistor_code <= '0;
			samples.light_code_raw <= '0;
			send_gap <= 0;
		end else begin
			if (samples.valid && samples.ready) begin
				expected_readings.push_back(predict_reading(
					{samples.thermistor_code, samples.light_code_raw}));
			end
			if (!samples.valid || samples.ready) begin
				if (send_gap > 0 || hold_sender || pending_samples.size() == 0) begin
					samples.valid <= 1'b0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end else begin
					samples.valid <= 1'b1;
					{samples.thermistor_code, samples.light_code_raw} <=
						pending_samples.pop_front();
					send_gap <= pick_gap();
				end
			end
		end
	end

	// Monitor: random back-pressure and an in-order check of every result.
	always @(posedge clk or negedge arst_n) begin
		reading_t got, want;
		if (!arst_n) begin
			results.ready <= 1'b0;
			take_gap <= 0;
		end else begin
			if (results.valid && results.ready) begin
				got = {results.temp_tenths, results.over_temp, results.temp_status,
					results.light_band, results.light_percent, results.light_status};
				if (expected_readings.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_readings.pop_front();
					if (got !== want) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (take_gap > 0) begin
				results.ready <= 1'b0;
				take_gap <= take_gap - 1;
			end else begin
				results.ready <= 1'b1;
				take_gap <= pick_gap();
			end
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() != 0 || samples.valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Drives one write for one edge; the caller lowers the enable after the last one.
	task automatic write_reg(input cfg_reg_t idx, input logic [13:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		case (idx)
			REG_BETA:       beta_k = value;
			REG_DARK:       dark_lim = value[11:0];
			REG_BRIGHT:     bright_lim = value[11:0];
			REG_ALARM:      alarm_t = value[12:0];
			REG_WARN:       warn_t = value[12:0];
			REG_LIGHT_HIGH: high_pct = value[6:0];
			REG_LIGHT_MID:  mid_pct = value[6:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [13:0] b, input logic [11:0] d, input logic [11:0] br,
		input logic signed [12:0] al, input logic signed [12:0] wn,
		input logic [6:0] hp, input logic [6:0] mp);
		write_reg(REG_BETA, b);
		write_reg(REG_DARK, d);
		write_reg(REG_BRIGHT, br);
		write_reg(REG_ALARM, 14'(al));
		write_reg(REG_WARN, 14'(wn));
		write_reg(REG_LIGHT_HIGH, hp);
		write_reg(REG_LIGHT_MID, mp);
		wr_en <= 1'b0;
	endtask

	task automatic queue_random(input int count);
		sample_t s;
		for (int i = 0; i < count; i++) begin
			s.therm = $urandom_range(0, 99) < 10 ? 12'($urandom_range(0, 20)) : 12'($urandom);
			s.light = 12'($urandom);
			if ($urandom_range(0, 19) == 0) s.therm = 12'(ADC_MAX - $urandom_range(0, 20));
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		sample_t s;
		beta_k = 3950; dark_lim = 500; bright_lim = 1000;
		alarm_t = 400; warn_t = 300; high_pct = 80; mid_pct = 40;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset values: clamp edges, mid scale, band and percent edges.
		for (int i = 0; i < 12; i++) begin
			s.therm = dir_therm[i];
			s.light = dir_light[i];
			pending_samples.push_back(s);
		end
		wait_drained();

		// Small beta lets the denominator go non-positive; crossed light limits.
		write_all(14'd1000, 12'd3000, 12'd100, -13'sd1000, -13'sd1000, 7'd0, 7'd0);
		for (int i = 0; i < 8; i++) begin
			s.therm = sweep_therm[i];
			s.light = 12'($urandom);
			pending_samples.push_back(s);
		end
		wait_drained();

		// Beta zero: zero kelvin or the hot result; other registers at their upper extremes.
		write_all(14'd0, 12'd4095, 12'd4095, 13'sd3000, 13'sd3000, 7'd127, 7'd100);
		queue_random(6);
		wait_drained();

		// Upper beta extreme and the full register width.
		write_all(14'h3FFF, 12'd0, 12'd0, 13'sd0, -13'sd500, 7'd100, 7'd50);
		queue_random(100);
		wait_drained();

		// Sender holds until every expected result is back, then resumes.
		hold_sender = 1'b0;
		write_all(14'd10000, 12'd2000, 12'd3000, 13'sd250, 13'sd200, 7'd60, 7'd30);
		queue_random(100);
		while (pending_samples.size() > 50) @(posedge clk);
		hold_sender = 1'b1;
		while (samples.valid || expected_readings.size() != 0) @(posedge clk);
		hold_sender = 1'b0;
		wait_drained();

		for (int k = 0; k < 3; k++) begin
			write_all(14'($urandom_range(1000, 10000)), 12'($urandom), 12'($urandom),
				13'($urandom_range(0, 4000) - 1000), 13'($urandom_range(0, 4000) - 1000),
				7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
			queue_random(100);
			wait_drained();
		end

		if (mismatch_count == 0 && expected_readings.size() == 0) begin
			$display("PASS thermistor_light_monitor_core");
		end else begin
			$display("FAIL thermistor_light_monitor_core");
		end
		$finish;
	end
endmodule

### thermistor_light_monitor_core.f
hw/rtl/tlm_pkg.sv
hw/rtl/tlm_in_if.sv
hw/rtl/tlm_out_if.sv
hw/rtl/tlm_log2_pipe.sv
hw/rtl/tlm_div_pipe.sv
hw/rtl/tlm_light.sv
hw/rtl/thermistor_light_monitor_core.sv
verif/thermistor_light_monitor_core_test.sv
